// ----- design/nsr_pkg.sv -----
// Shared types, character codes and helpers for the NMEA sentence receiver.
// No dependencies; every other design file refers to this package by scope.
package nsr_pkg;

    // Default sizes
    localparam int FRAME_SLOTS_DEF = 8;
    localparam int MAX_LENGTH_DEF  = 82;

    // Frame geometry
    localparam int SLOT_BYTES = 128;
    localparam int OFF_W      = 7;
    localparam int LEN_W      = 7;
    localparam int DATA_W     = 32;

    // Statistic counters
    localparam int NUM_STATS  = 7;
    localparam int STAT_IDX_W = 3;
    localparam logic [STAT_IDX_W-1:0] STAT_VALID    = 3'd0;
    localparam logic [STAT_IDX_W-1:0] STAT_RELEASED = 3'd1;
    localparam logic [STAT_IDX_W-1:0] STAT_INVALID  = 3'd2;
    localparam logic [STAT_IDX_W-1:0] STAT_FORMAT   = 3'd3;
    localparam logic [STAT_IDX_W-1:0] STAT_CSUM     = 3'd4;
    localparam logic [STAT_IDX_W-1:0] STAT_TOO_LONG = 3'd5;
    localparam logic [STAT_IDX_W-1:0] STAT_OVERRUN  = 3'd6;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    // Item functions
    localparam logic [1:0] FUNC_RX      = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;
    localparam logic [1:0] FUNC_STAT    = 2'd3;

    // Per-byte parse outcome
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_ACCEPTED  = 3'd1,
        EV_FORMAT    = 3'd2,
        EV_CHECKSUM  = 3'd3,
        EV_TOO_LONG  = 3'd4,
        EV_OVERRUN   = 3'd5
    } event_t;

    // Byte write into the current frame slot
    typedef struct packed {
        logic             en;
        logic [OFF_W-1:0] off;
        logic [7:0]       data;
    } store_t;

    // Good sentence handed to the ring
    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] len;
    } commit_t;

    // Uppercase ASCII hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
            r = CH_ZERO + {4'b0000, v};
        else
            r = CH_UPPER_A + {4'b0000, v} - 8'd10;
        return r;
    endfunction

endpackage

// ----- design/nsr_parser.sv -----
// Sentence parser: sync, '$' start, checksum up to '*', tail checks at LF.
// Depends on nsr_pkg.
module nsr_parser #(
    parameter int MAX_LENGTH = nsr_pkg::MAX_LENGTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic [7:0]          rx_byte,
    input  logic                ring_full,
    output nsr_pkg::event_t     ev,
    output nsr_pkg::store_t     store,
    output nsr_pkg::commit_t    commit
);

    typedef enum logic [1:0] {
        PS_SYNCH,
        PS_IDLE,
        PS_READ,
        PS_EOF
    } pstate_t;

    localparam logic [nsr_pkg::LEN_W-1:0] MAX_LEN = nsr_pkg::LEN_W'(MAX_LENGTH);
    localparam logic [nsr_pkg::LEN_W-1:0] MIN_LEN = nsr_pkg::LEN_W'(5);

    pstate_t                     state_reg, state_next;
    logic [7:0]                  csum_reg, csum_next;
    logic [nsr_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [31:0]                 tail_reg, tail_next;
    logic                        dropped_reg, dropped_next;

    logic [nsr_pkg::LEN_W-1:0]   len_inc;
    logic [31:0]                 tail_shift;
    logic [7:0]                  fifth;
    logic                        fmt_bad;
    logic                        sum_bad;

    assign len_inc    = len_reg + nsr_pkg::LEN_W'(1);
    assign tail_shift = {tail_reg[23:0], rx_byte};
    assign fifth      = tail_reg[31:24];

    // Tail before the LF: newest is CR, then low digit, high digit, '*'
    assign fmt_bad = (len_inc < MIN_LEN) || (tail_reg[7:0] != nsr_pkg::CH_CR)
                     || (fifth != nsr_pkg::CH_STAR);
    assign sum_bad = (tail_reg[15:8] != nsr_pkg::hex_digit(csum_reg[3:0]))
                     || (tail_reg[23:16] != nsr_pkg::hex_digit(csum_reg[7:4]));

    // Next state per received byte
    always_comb
    begin
        state_next   = state_reg;
        csum_next    = csum_reg;
        len_next     = len_reg;
        tail_next    = tail_reg;
        dropped_next = dropped_reg;
        ev           = nsr_pkg::EV_NONE;
        store        = '0;
        commit       = '0;
        if (byte_valid)
        begin
            case (state_reg)
                PS_SYNCH:
                begin
                    if (rx_byte == nsr_pkg::CH_LF)
                        state_next = PS_IDLE;
                end
                PS_IDLE:
                begin
                    if (rx_byte == nsr_pkg::CH_START)
                    begin
                        dropped_next = ring_full;
                        csum_next    = '0;
                        len_next     = nsr_pkg::LEN_W'(1);
                        tail_next    = {24'd0, rx_byte};
                        store.en     = !ring_full;
                        store.off    = '0;
                        store.data   = rx_byte;
                        state_next   = PS_READ;
                    end
                end
                PS_READ:
                begin
                    len_next   = len_inc;
                    tail_next  = tail_shift;
                    store.en   = !dropped_reg;
                    store.off  = len_reg;
                    store.data = rx_byte;
                    if (len_inc >= MAX_LEN)
                    begin
                        ev         = nsr_pkg::EV_TOO_LONG;
                        state_next = PS_SYNCH;
                    end
                    else if (rx_byte == nsr_pkg::CH_STAR)
                        state_next = PS_EOF;
                    else
                        csum_next = csum_reg ^ rx_byte;
                end
                PS_EOF:
                begin
                    len_next   = len_inc;
                    tail_next  = tail_shift;
                    store.en   = !dropped_reg;
                    store.off  = len_reg;
                    store.data = rx_byte;
                    if (rx_byte != nsr_pkg::CH_LF)
                    begin
                        if (len_inc >= MAX_LEN)
                        begin
                            ev         = nsr_pkg::EV_TOO_LONG;
                            state_next = PS_SYNCH;
                        end
                    end
                    else
                    begin
                        state_next = PS_IDLE;
                        if (fmt_bad)
                            ev = nsr_pkg::EV_FORMAT;
                        else if (sum_bad)
                            ev = nsr_pkg::EV_CHECKSUM;
                        else if (dropped_reg)
                            ev = nsr_pkg::EV_OVERRUN;
                        else
                        begin
                            ev         = nsr_pkg::EV_ACCEPTED;
                            commit.en  = 1'b1;
                            commit.len = len_inc;
                        end
                    end
                end
                default:
                begin
                    state_next = PS_SYNCH;
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= PS_SYNCH;
            csum_reg    <= '0;
            len_reg     <= '0;
            tail_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            csum_reg    <= csum_next;
            len_reg     <= len_next;
            tail_reg    <= tail_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

// ----- design/nsr_ring.sv -----
// Ring of frame slots: byte store, slot lengths, write/read pointers, fill count.
// Depends on nsr_pkg.
module nsr_ring #(
    parameter int FRAME_SLOTS = nsr_pkg::FRAME_SLOTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nsr_pkg::store_t                      store,
    input  nsr_pkg::commit_t                     commit,
    input  logic                                 rel,
    input  logic                                 rd_en,
    input  logic [nsr_pkg::OFF_W-1:0]            rd_off,
    output logic [7:0]                           rd_data,
    output logic [nsr_pkg::LEN_W-1:0]            oldest_len,
    output logic [$clog2(FRAME_SLOTS+1)-1:0]     waiting,
    output logic                                 full
);

    localparam int SLOT_W  = $clog2(FRAME_SLOTS);
    localparam int CNT_W   = $clog2(FRAME_SLOTS + 1);
    localparam int DEPTH   = FRAME_SLOTS * nsr_pkg::SLOT_BYTES;
    localparam int ADDR_W  = SLOT_W + nsr_pkg::OFF_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);

    logic [7:0]               frame_mem [DEPTH];
    logic [nsr_pkg::LEN_W-1:0] len_mem  [FRAME_SLOTS];

    logic [SLOT_W-1:0]        wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0]        rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [7:0]               rd_data_reg;
    logic [nsr_pkg::LEN_W-1:0] len_rd_reg;

    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;

    assign wr_addr = {wr_slot_reg, store.off};
    assign rd_addr = {rd_slot_reg, rd_off};

    // Pointer and fill count update
    always_comb
    begin
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        count_next   = count_reg;
        if (commit.en)
        begin
            wr_slot_next = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + SLOT_W'(1);
            count_next   = count_reg + CNT_W'(1);
        end
        else if (rel)
        begin
            rd_slot_next = (rd_slot_reg == LAST_SLOT) ? '0 : rd_slot_reg + SLOT_W'(1);
            count_next   = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_slot_reg <= '0;
            rd_slot_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            count_reg   <= count_next;
        end
    end

    // Frame byte store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (store.en)
            frame_mem[wr_addr] <= store.data;
        if (rd_en)
            rd_data_reg <= frame_mem[rd_addr];
    end

    // Slot lengths; read follows the next read pointer, bypass on a same-slot write
    always_ff @(posedge clk)
    begin
        if (commit.en)
            len_mem[wr_slot_reg] <= commit.len;
        if (commit.en && (wr_slot_reg == rd_slot_next))
            len_rd_reg <= commit.len;
        else
            len_rd_reg <= len_mem[rd_slot_next];
    end

    assign rd_data    = rd_data_reg;
    assign oldest_len = len_rd_reg;
    assign waiting    = count_reg;
    assign full       = (count_reg >= CNT_W'(FRAME_SLOTS));

endmodule

// ----- design/nsr_stats.sv -----
// Seven wrapping 32-bit statistic counters with a read port by index.
// Depends on nsr_pkg.
module nsr_stats (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nsr_pkg::event_t                 ev,
    input  logic                            rel,
    input  logic [nsr_pkg::OFF_W-1:0]       rd_idx,
    output logic [nsr_pkg::DATA_W-1:0]      rd_data
);

    logic [nsr_pkg::DATA_W-1:0] cnt_reg [nsr_pkg::NUM_STATS];
    logic [nsr_pkg::NUM_STATS-1:0] inc;

    // Which counters step for this beat
    always_comb
    begin
        inc = '0;
        case (ev)
            nsr_pkg::EV_ACCEPTED: inc[nsr_pkg::STAT_VALID] = 1'b1;
            nsr_pkg::EV_FORMAT:
            begin
                inc[nsr_pkg::STAT_FORMAT]  = 1'b1;
                inc[nsr_pkg::STAT_INVALID] = 1'b1;
            end
            nsr_pkg::EV_CHECKSUM:
            begin
                inc[nsr_pkg::STAT_CSUM]    = 1'b1;
                inc[nsr_pkg::STAT_INVALID] = 1'b1;
            end
            nsr_pkg::EV_TOO_LONG: inc[nsr_pkg::STAT_TOO_LONG] = 1'b1;
            nsr_pkg::EV_OVERRUN:  inc[nsr_pkg::STAT_OVERRUN]  = 1'b1;
            default:              inc = '0;
        endcase
        if (rel)
            inc[nsr_pkg::STAT_RELEASED] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < nsr_pkg::NUM_STATS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < nsr_pkg::NUM_STATS; i++)
                if (inc[i])
                    cnt_reg[i] <= cnt_reg[i] + nsr_pkg::DATA_W'(1);
        end
    end

    // Out-of-range index reads zero
    assign rd_data = (rd_idx < nsr_pkg::OFF_W'(nsr_pkg::NUM_STATS))
                     ? cnt_reg[rd_idx[nsr_pkg::STAT_IDX_W-1:0]] : '0;

endmodule

// ----- design/nmea_sentence_receiver.sv -----
// NMEA 0183 sentence receiver: parser, frame ring and statistics behind a
// two-register pipeline (issue register, then result register).
// Throughput: one beat per cycle while out_ready lets the result register drain;
// the frame store read in the issue cycle sets the depth.
// Reset (rst_n, async, active low) clears parser, pointers, counters and valids;
// frame and length stores are not cleared, so no clearing pass is needed.
module nmea_sentence_receiver #(
    parameter int FRAME_SLOTS = nsr_pkg::FRAME_SLOTS_DEF,
    parameter int MAX_LENGTH  = nsr_pkg::MAX_LENGTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           func,
    input  logic [7:0]                           rx_byte,
    input  logic [nsr_pkg::OFF_W-1:0]            offset,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0]                           event_res,
    output logic [nsr_pkg::DATA_W-1:0]           read_data,
    output logic [nsr_pkg::LEN_W-1:0]            oldest_length,
    output logic [$clog2(FRAME_SLOTS+1)-1:0]     frames_waiting
);

    localparam int CNT_W = $clog2(FRAME_SLOTS + 1);

    logic                         in_acc;
    logic                         res_ready;
    logic                         rel;
    nsr_pkg::event_t              ev;
    nsr_pkg::store_t              store;
    nsr_pkg::commit_t             commit;
    logic                         full;
    logic [7:0]                   frame_byte;
    logic [nsr_pkg::LEN_W-1:0]    oldest_len;
    logic [CNT_W-1:0]             waiting;
    logic [nsr_pkg::DATA_W-1:0]   stat_data;
    logic [nsr_pkg::DATA_W-1:0]   data_sel;

    // Issue register
    logic                         iss_valid_reg;
    nsr_pkg::event_t              iss_ev_reg;
    logic [1:0]                   iss_func_reg;
    logic [nsr_pkg::OFF_W-1:0]    iss_off_reg;

    // Result register
    logic                         out_valid_reg;
    nsr_pkg::event_t              out_ev_reg;
    logic [nsr_pkg::DATA_W-1:0]   out_data_reg;
    logic [nsr_pkg::LEN_W-1:0]    out_len_reg;
    logic [CNT_W-1:0]             out_wait_reg;

    // Handshake
    assign res_ready = !out_valid_reg || out_ready;
    assign in_ready  = !iss_valid_reg || res_ready;
    assign in_acc    = in_valid && in_ready;
    assign rel       = in_acc && (func == nsr_pkg::FUNC_RELEASE) && (waiting != '0);

    nsr_parser #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_acc && (func == nsr_pkg::FUNC_RX)),
        .rx_byte    (rx_byte),
        .ring_full  (full),
        .ev         (ev),
        .store      (store),
        .commit     (commit)
    );

    nsr_ring #(
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .store      (store),
        .commit     (commit),
        .rel        (rel),
        .rd_en      (in_acc && (func == nsr_pkg::FUNC_READ)),
        .rd_off     (offset),
        .rd_data    (frame_byte),
        .oldest_len (oldest_len),
        .waiting    (waiting),
        .full       (full)
    );

    // Statistics read by the beat in the issue register; reads change no counter
    nsr_stats u_stats (
        .clk     (clk),
        .rst_n   (rst_n),
        .ev      (ev),
        .rel     (rel),
        .rd_idx  (iss_off_reg),
        .rd_data (stat_data)
    );

    // Ring state while a beat sits in the issue register is exactly its after-state
    always_comb
    begin
        data_sel = '0;
        case (iss_func_reg)
            nsr_pkg::FUNC_READ:
            begin
                if ((waiting != '0) && (iss_off_reg < oldest_len))
                    data_sel = {24'd0, frame_byte};
            end
            nsr_pkg::FUNC_STAT: data_sel = stat_data;
            default:            data_sel = '0;
        endcase
    end

    // Issue register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iss_valid_reg <= 1'b0;
        else if (in_acc)
            iss_valid_reg <= 1'b1;
        else if (res_ready)
            iss_valid_reg <= 1'b0;
    end

    // Issue register payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            iss_ev_reg   <= ev;
            iss_func_reg <= func;
            iss_off_reg  <= offset;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= iss_valid_reg;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (res_ready && iss_valid_reg)
        begin
            out_ev_reg   <= iss_ev_reg;
            out_data_reg <= data_sel;
            out_len_reg  <= (waiting != '0) ? oldest_len : '0;
            out_wait_reg <= waiting;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = out_ev_reg;
    assign read_data      = out_data_reg;
    assign oldest_length  = out_len_reg;
    assign frames_waiting = out_wait_reg;

endmodule
